/* rtl/rrwl_pkg.sv */
package rrwl_pkg;

	localparam int KIND_W   = 3;
	localparam int CLIENT_W = 4;
	localparam int LIMIT_W  = 32;
	localparam int STATUS_W = 2;
	localparam int MODE_W   = 2;
	localparam int TOTAL_W  = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOCK_RD   = 3'd0,
		KIND_LOCK_WR   = 3'd1,
		KIND_UNLOCK    = 3'd2,
		KIND_WAIT_FREE = 3'd3,
		KIND_FORCE_REL = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_AGAIN   = 2'd2,
		ST_WAIT    = 2'd3
	} status_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_FREE  = 2'd0,
		MODE_READ  = 2'd1,
		MODE_WRITE = 2'd2
	} mode_t;

endpackage

/* rtl/rrwl_ram.sv */
module rrwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/recursive_reader_writer_lock.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+--------------------------------------------
// request  | in_valid / in_stall  | kind, client, no_block, wait_limit_ms
// result   | out_valid / out_stall| status, mode_now, owner_total
//
// One request per cycle while results are taken; a result is registered after its
// request transfer (count memory read and stage 1 capture at that edge, then update
// into the output register), where it waits until it transfers.
// Recursion counts sit in a one-port-read RAM; a write forwarded to the next read.
// Reset clears mode, owner bits and owner count at once; no memory clearing pass.
// A stalled result holds the update stage, which then stalls the request side.
module recursive_reader_writer_lock #(
	parameter int NUM_CLIENTS = 16,
	parameter int COUNT_BITS  = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [rrwl_pkg::KIND_W-1:0]      kind,
	input  logic [rrwl_pkg::CLIENT_W-1:0]    client,
	input  logic                             no_block,
	input  logic [rrwl_pkg::LIMIT_W-1:0]     wait_limit_ms,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [rrwl_pkg::STATUS_W-1:0]    status,
	output logic [rrwl_pkg::MODE_W-1:0]      mode_now,
	output logic [rrwl_pkg::TOTAL_W-1:0]     owner_total
);

	import rrwl_pkg::*;

	localparam int CW = $clog2(NUM_CLIENTS);
	localparam int NW = $clog2(NUM_CLIENTS + 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
	localparam logic [NW-1:0] OWN_ONE = NW'(1);

	// architectural state
	mode_t                  mode_q;
	logic [NUM_CLIENTS-1:0] owner_q;
	logic [NW-1:0]          cnt_q;

	// stage 1: request waiting on count read
	logic                   valid_s1;
	kind_t                  kind_s1;
	logic [CW-1:0]          idx_s1;
	logic                   in_range_s1;
	logic                   no_block_s1;
	logic                   limit_zero_s1;
	logic                   fwd_hit_s1;
	logic [COUNT_BITS-1:0]  fwd_data_s1;

	// output register
	logic                   out_valid_q;
	status_t                status_q;
	mode_t                  mode_now_q;
	logic [NW-1:0]          total_q;

	logic                   accept;
	logic                   adv;
	logic [CW-1:0]          rd_idx;
	logic [COUNT_BITS-1:0]  rdata;
	logic [COUNT_BITS-1:0]  cur;
	logic                   own;

	status_t                st_d;
	mode_t                  mode_d;
	logic [NUM_CLIENTS-1:0] owner_d;
	logic [NW-1:0]          cnt_d;
	logic                   we;
	logic [COUNT_BITS-1:0]  wdata;
	mode_t                  want;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign rd_idx   = CW'(client);

	rrwl_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_CLIENTS)
	) u_count_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (rd_idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture request, and any write landing on the same entry in this cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1       <= kind_t'(kind);
			idx_s1        <= rd_idx;
			in_range_s1   <= (32'(client) < NUM_CLIENTS);
			no_block_s1   <= no_block;
			limit_zero_s1 <= (wait_limit_ms == '0);
			fwd_hit_s1    <= we && (idx_s1 == rd_idx);
			fwd_data_s1   <= wdata;
		end
	end

	assign cur  = fwd_hit_s1 ? fwd_data_s1 : rdata;
	assign own  = in_range_s1 && owner_q[idx_s1];
	assign want = (kind_s1 == KIND_LOCK_WR) ? MODE_WRITE : MODE_READ;

	always_comb begin
		st_d    = ST_INVALID;
		mode_d  = mode_q;
		owner_d = owner_q;
		cnt_d   = cnt_q;
		we      = 1'b0;
		wdata   = '0;
		if (valid_s1 && in_range_s1) begin
			unique case (kind_s1) inside
				KIND_LOCK_RD, KIND_LOCK_WR: begin
					if (mode_q == MODE_FREE ||
					    (want == MODE_READ && mode_q == MODE_READ && !own)) begin
						owner_d[idx_s1] = 1'b1;
						cnt_d  = cnt_q + OWN_ONE;
						mode_d = want;
						we     = adv;
						wdata  = COUNT_ONE;
						st_d   = ST_OK;
					end else if (own) begin
						if (mode_q == want) begin
							if (cur != COUNT_MAX) begin
								we    = adv;
								wdata = cur + COUNT_ONE;
								st_d  = ST_OK;
							end
						end else if (want == MODE_READ && cur == COUNT_ONE) begin
							// downgrade a single write hold
							mode_d = MODE_READ;
							st_d   = ST_OK;
						end
					end else begin
						st_d = (no_block_s1 || limit_zero_s1) ? ST_AGAIN : ST_WAIT;
					end
				end
				KIND_UNLOCK: begin
					if (mode_q != MODE_FREE && own) begin
						st_d = ST_OK;
						we   = adv;
						if (cur <= COUNT_ONE) begin
							wdata           = '0;
							owner_d[idx_s1] = 1'b0;
							cnt_d           = cnt_q - OWN_ONE;
							if (cnt_q == OWN_ONE) begin
								mode_d = MODE_FREE;
							end
						end else begin
							wdata = cur - COUNT_ONE;
						end
					end
				end
				KIND_WAIT_FREE: begin
					if (mode_q == MODE_FREE) begin
						st_d = ST_OK;
					end else begin
						st_d = limit_zero_s1 ? ST_AGAIN : ST_WAIT;
					end
				end
				KIND_FORCE_REL: begin
					st_d  = ST_OK;
					we    = adv;
					wdata = '0;
					if (own) begin
						owner_d[idx_s1] = 1'b0;
						cnt_d           = cnt_q - OWN_ONE;
						if (cnt_q == OWN_ONE) begin
							mode_d = MODE_FREE;
						end
					end
				end
				default: begin
					st_d = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_FREE;
			owner_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				mode_q  <= mode_d;
				owner_q <= owner_d;
				cnt_q   <= cnt_d;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q   <= st_d;
			mode_now_q <= mode_d;
			total_q    <= cnt_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign mode_now    = mode_now_q;
	assign owner_total = TOTAL_W'(total_q);

`ifndef SYNTHESIS
	a_free_no_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_FREE) == (cnt_q == '0))
		else $error("lock mode and owner count disagree");

	a_count_matches_bits: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(owner_q))
		else $error("owner count does not match owner bits");

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_WRITE) |-> (cnt_q == OWN_ONE))
		else $error("write lock held by more than one client");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("completed request produced no result");
`endif

endmodule
